// ===== hdl/fwus_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwus_pkg
// Shared request/result codes, field widths and controller command type.
// ----------------------------------------------------------------------------
package fwus_pkg;

  localparam int REQ_W   = 2;
  localparam int ID_W    = 16;
  localparam int PRIO_W  = 8;
  localparam int CODE_W  = 3;
  localparam int COUNT_W = 6;

  localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EXECUTE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UNDO    = 2'd2;

  localparam logic [CODE_W-1:0] RES_OK          = 3'd0;
  localparam logic [CODE_W-1:0] RES_FIFO_FULL   = 3'd1;
  localparam logic [CODE_W-1:0] RES_FIFO_EMPTY  = 3'd2;
  localparam logic [CODE_W-1:0] RES_STACK_EMPTY = 3'd3;
  localparam logic [CODE_W-1:0] RES_STACK_LOST  = 3'd4;
  localparam logic [CODE_W-1:0] RES_FIFO_LOST   = 3'd5;

  typedef struct packed {
    logic capture;  // latch request, read both stores
    logic commit;   // apply request, load result register
  } fwus_cmd_t;

endpackage

// ===== hdl/fwus_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwus_ctrl
// Sequencer: accepts a request, waits in the exec state for the store
// reads, then commits once the result register is free.
// ----------------------------------------------------------------------------
module fwus_ctrl
  import fwus_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output fwus_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready    = (state_r == ST_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.commit  = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.capture) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.commit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit in same cycle");

  a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_EXEC))
    else $error("capture did not enter exec");

  a_commit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not raise out_valid");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) && out_valid_r && !out_ready |=> (state_r == ST_EXEC))
    else $error("exec left while result register blocked");

endmodule

// ===== hdl/fwus_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwus_dp
// Datapath: FIFO and stack memories, pointers, counts and result register.
// ----------------------------------------------------------------------------
module fwus_dp
  import fwus_pkg::*;
#(
  parameter int FIFO_DEPTH  = 32,
  parameter int STACK_DEPTH = 32,
  parameter int ID_BITS     = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fwus_cmd_t         cmd,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [ID_W-1:0]   in_package_id,
  input  logic [PRIO_W-1:0] in_package_priority,
  output logic [CODE_W-1:0] out_result_code,
  output logic [ID_W-1:0]   out_moved_id,
  output logic [PRIO_W-1:0] out_moved_priority,
  output logic [COUNT_W-1:0] out_fifo_count,
  output logic [COUNT_W-1:0] out_stack_count
);

  localparam int ENTRY_W = ID_BITS + PRIO_W;
  localparam int FAW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCW = $clog2(FIFO_DEPTH + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  logic [ENTRY_W-1:0] fifo_mem [FIFO_DEPTH];
  logic [ENTRY_W-1:0] stack_mem [STACK_DEPTH];

  logic [FAW-1:0] head_r, head_nxt;
  logic [FCW-1:0] fifo_used_r, fifo_used_nxt;
  logic [SCW-1:0] stack_used_r, stack_used_nxt;

  logic [REQ_W-1:0]   req_r;
  logic [ENTRY_W-1:0] new_entry_r;
  logic [ENTRY_W-1:0] fifo_rd_r;
  logic [ENTRY_W-1:0] stack_rd_r;

  logic [CODE_W-1:0]  code_r;
  logic [ENTRY_W-1:0] moved_r;
  logic [COUNT_W-1:0] fifo_cnt_r;
  logic [COUNT_W-1:0] stack_cnt_r;

  logic               fifo_full, fifo_empty, stack_full, stack_empty;
  logic [FCW:0]       tail_sum;
  logic [FAW-1:0]     tail;
  logic               fifo_we, stack_we;
  logic [CODE_W-1:0]  code;
  logic [ENTRY_W-1:0] entry;

  assign fifo_full   = (fifo_used_r == FCW'(FIFO_DEPTH));
  assign fifo_empty  = (fifo_used_r == '0);
  assign stack_full  = (stack_used_r == SCW'(STACK_DEPTH));
  assign stack_empty = (stack_used_r == '0);

  assign tail_sum = (FCW+1)'(head_r) + (FCW+1)'(fifo_used_r);
  assign tail = (tail_sum >= (FCW+1)'(FIFO_DEPTH)) ?
                FAW'(tail_sum - (FCW+1)'(FIFO_DEPTH)) : FAW'(tail_sum);

  always_comb begin
    head_nxt       = head_r;
    fifo_used_nxt  = fifo_used_r;
    stack_used_nxt = stack_used_r;
    fifo_we        = 1'b0;
    stack_we       = 1'b0;
    code           = RES_OK;
    entry          = '0;
    case (req_r)
      REQ_ENQUEUE: begin
        if (fifo_full) begin
          code = RES_FIFO_FULL;
        end else begin
          entry         = new_entry_r;
          fifo_we       = 1'b1;
          fifo_used_nxt = fifo_used_r + FCW'(1);
        end
      end
      REQ_EXECUTE: begin
        if (fifo_empty) begin
          code = RES_FIFO_EMPTY;
        end else begin
          entry         = fifo_rd_r;
          head_nxt      = (head_r == FAW'(FIFO_DEPTH - 1)) ? '0 : head_r + FAW'(1);
          fifo_used_nxt = fifo_used_r - FCW'(1);
          if (stack_full) begin
            code = RES_STACK_LOST;
          end else begin
            stack_we       = 1'b1;
            stack_used_nxt = stack_used_r + SCW'(1);
          end
        end
      end
      REQ_UNDO: begin
        if (stack_empty) begin
          code = RES_STACK_EMPTY;
        end else begin
          entry          = stack_rd_r;
          stack_used_nxt = stack_used_r - SCW'(1);
          if (fifo_full) begin
            code = RES_FIFO_LOST;
          end else begin
            fifo_we       = 1'b1;
            fifo_used_nxt = fifo_used_r + FCW'(1);
          end
        end
      end
      default: code = RES_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && fifo_we) fifo_mem[tail] <= entry;
    if (cmd.capture) fifo_rd_r <= fifo_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && stack_we) stack_mem[SAW'(stack_used_r)] <= entry;
    if (cmd.capture) stack_rd_r <= stack_mem[SAW'(stack_used_r - SCW'(1))];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r       <= in_req_type;
      new_entry_r <= {in_package_priority, ID_BITS'(in_package_id)};
    end
    if (cmd.commit) begin
      code_r      <= code;
      moved_r     <= entry;
      fifo_cnt_r  <= COUNT_W'(fifo_used_nxt);
      stack_cnt_r <= COUNT_W'(stack_used_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      fifo_used_r  <= '0;
      stack_used_r <= '0;
    end else if (cmd.commit) begin
      head_r       <= head_nxt;
      fifo_used_r  <= fifo_used_nxt;
      stack_used_r <= stack_used_nxt;
    end
  end

  assign out_result_code    = code_r;
  assign out_moved_id       = ID_W'(moved_r[ID_BITS-1:0]);
  assign out_moved_priority = moved_r[ENTRY_W-1:ID_BITS];
  assign out_fifo_count     = fifo_cnt_r;
  assign out_stack_count    = stack_cnt_r;

endmodule

// ===== hdl/fifo_with_undo_stack_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_undo_stack_core
// Circular pending queue with a history stack for undo.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one request per transaction, req_type
// 0 enqueue (package_id, package_priority), 1 execute (queue head onto the
// stack), 2 undo (stack top back to the queue tail).
// Result channel (out_valid/out_ready): one transaction per request with the
// status code, the entry moved (zero if none) and both occupancy counts
// after the request.
// Each request passes through two steps: capture reads the queue head and
// stack top from the synchronous-read memories, commit updates pointers,
// writes back and loads the result register. A new request is accepted
// only after the previous one has committed.
// The result register sits between the sides: a new request is accepted
// while a result waits, and its commit holds until that result is taken.
// Reset empties the queue and stack at once (pointers and counts only; no
// clearing pass). A stalled receiver holds the result steady.
// ----------------------------------------------------------------------------
module fifo_with_undo_stack_core
  import fwus_pkg::*;
#(
  parameter int FIFO_DEPTH  = 32,
  parameter int STACK_DEPTH = 32,
  parameter int ID_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [ID_W-1:0]    in_package_id,
  input  logic [PRIO_W-1:0]  in_package_priority,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CODE_W-1:0]  out_result_code,
  output logic [ID_W-1:0]    out_moved_id,
  output logic [PRIO_W-1:0]  out_moved_priority,
  output logic [COUNT_W-1:0] out_fifo_count,
  output logic [COUNT_W-1:0] out_stack_count
);

  fwus_cmd_t cmd;

  fwus_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  fwus_dp #(
    .FIFO_DEPTH  (FIFO_DEPTH),
    .STACK_DEPTH (STACK_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_req_type         (in_req_type),
    .in_package_id       (in_package_id),
    .in_package_priority (in_package_priority),
    .out_result_code     (out_result_code),
    .out_moved_id        (out_moved_id),
    .out_moved_priority  (out_moved_priority),
    .out_fifo_count      (out_fifo_count),
    .out_stack_count     (out_stack_count)
  );

endmodule

// ===== sim/fifo_with_undo_stack_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_undo_stack_core_tb
// Drives enqueue, execute, undo and reserved requests into the pending
// queue and its history stack under random idling on both sides. Every
// result transaction is checked against a testbench model of both stores.
// ----------------------------------------------------------------------------
module fifo_with_undo_stack_core_tb;
  import fwus_pkg::*;

  localparam int QUEUE_DEPTH   = 32;
  localparam int HISTORY_DEPTH = 32;
  localparam int CHUNKS        = 8;
  localparam int CHUNK_ITEMS   = 50;
  localparam int LONG_HOLD     = 80;
  localparam int STALL_LIMIT   = 1000;

  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } parcel_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [COUNT_W-1:0] queue_cnt;
    logic [COUNT_W-1:0] history_cnt;
  } dispatch_result_t;

  class dispatch_scoreboard;
    parcel_t          queue_mem[QUEUE_DEPTH];
    parcel_t          history_mem[HISTORY_DEPTH];
    int               queue_head;
    int               queue_used;
    int               history_used;
    int               errors;
    dispatch_result_t expected_results[$];

    function new();
      queue_head   = 0;
      queue_used   = 0;
      history_used = 0;
      errors       = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void append_queue(parcel_t p);
      queue_mem[(queue_head + queue_used) % QUEUE_DEPTH] = p;
      queue_used++;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                               logic [PRIO_W-1:0] prio);
      dispatch_result_t r;
      parcel_t          p;
      r = '0;
      p = '0;
      case (req)
        REQ_ENQUEUE: begin
          if (queue_used >= QUEUE_DEPTH) begin
            r.code = RES_FIFO_FULL;
          end else begin
            p.id   = id;
            p.prio = prio;
            append_queue(p);
          end
        end
        REQ_EXECUTE: begin
          if (queue_used == 0) begin
            r.code = RES_FIFO_EMPTY;
          end else begin
            p          = queue_mem[queue_head];
            queue_head = (queue_head + 1) % QUEUE_DEPTH;
            queue_used--;
            if (history_used >= HISTORY_DEPTH) begin
              r.code = RES_STACK_LOST;
            end else begin
              history_mem[history_used] = p;
              history_used++;
            end
          end
        end
        REQ_UNDO: begin
          if (history_used == 0) begin
            r.code = RES_STACK_EMPTY;
          end else begin
            history_used--;
            p = history_mem[history_used];
            if (queue_used >= QUEUE_DEPTH) begin
              r.code = RES_FIFO_LOST;
            end else begin
              append_queue(p);
            end
          end
        end
        default: begin
          r.code = RES_OK;
        end
      endcase
      r.id          = p.id;
      r.prio        = p.prio;
      r.queue_cnt   = COUNT_W'(queue_used);
      r.history_cnt = COUNT_W'(history_used);
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(dispatch_result_t got);
      dispatch_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction, expected none, actual code %0d id %0d",
                 $time, got.code, got.id);
        return;
      end
      want = expected_results.pop_front();
      compare_field("result_code", want.code, got.code);
      compare_field("moved_id", want.id, got.id);
      compare_field("moved_priority", want.prio, got.prio);
      compare_field("fifo_count", want.queue_cnt, got.queue_cnt);
      compare_field("stack_count", want.history_cnt, got.history_cnt);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [REQ_W-1:0]   in_req_type;
  logic [ID_W-1:0]    in_package_id;
  logic [PRIO_W-1:0]  in_package_priority;
  logic               out_valid;
  logic               out_ready;
  logic [CODE_W-1:0]  out_result_code;
  logic [ID_W-1:0]    out_moved_id;
  logic [PRIO_W-1:0]  out_moved_priority;
  logic [COUNT_W-1:0] out_fifo_count;
  logic [COUNT_W-1:0] out_stack_count;

  dispatch_scoreboard sb = new();
  bit                 calm;
  bit                 long_hold_req;
  int                 stall_cycles;

  fifo_with_undo_stack_core #(
    .FIFO_DEPTH (QUEUE_DEPTH),
    .STACK_DEPTH(HISTORY_DEPTH),
    .ID_BITS    (ID_W)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_package_id      (in_package_id),
    .in_package_priority(in_package_priority),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_code    (out_result_code),
    .out_moved_id       (out_moved_id),
    .out_moved_priority (out_moved_priority),
    .out_fifo_count     (out_fifo_count),
    .out_stack_count    (out_stack_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int idle_cycles();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ID_W'($urandom);
  endfunction

  function automatic logic [PRIO_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PRIO_W'($urandom);
  endfunction

  task automatic send_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                              logic [PRIO_W-1:0] prio);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_req_type         <= req;
    in_package_id       <= id;
    in_package_priority <= prio;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, id, prio);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // result receiver
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else begin
        hold_left = idle_cycles();
        if (hold_left > 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    dispatch_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.code        = out_result_code;
      got.id          = out_moved_id;
      got.prio        = out_moved_priority;
      got.queue_cnt   = out_fifo_count;
      got.history_cnt = out_stack_count;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time, sb.pending());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int enq_pct[CHUNKS];
    int exec_pct[CHUNKS];
    int r;
    logic [REQ_W-1:0] req;

    enq_pct       = '{40, 85, 15, 85, 10, 15, 10, 40};
    exec_pct      = '{30, 10, 80, 10, 10, 80, 10, 30};
    calm          = 1'b0;
    long_hold_req = 1'b0;
    stall_cycles  = 0;
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_req_type         <= REQ_ENQUEUE;
    in_package_id       <= '0;
    in_package_priority <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty stores, reserved request, field extremes
    send_request(REQ_EXECUTE, 16'h1234, 8'h56);
    send_request(REQ_UNDO, 16'hffff, 8'hff);
    send_request(REQ_RESERVED, 16'hffff, 8'hff);
    send_request(REQ_ENQUEUE, 16'hffff, 8'hff);
    send_request(REQ_ENQUEUE, 16'h0000, 8'h00);
    send_request(REQ_ENQUEUE, 16'haaaa, 8'h55);
    send_request(REQ_ENQUEUE, 16'h5555, 8'haa);
    send_request(REQ_EXECUTE, 16'h0000, 8'h00);
    send_request(REQ_EXECUTE, 16'hffff, 8'hff);
    send_request(REQ_RESERVED, 16'h0000, 8'h00);
    send_request(REQ_UNDO, 16'h0000, 8'h00);
    send_request(REQ_UNDO, 16'h0000, 8'h00);
    send_request(REQ_UNDO, 16'h0000, 8'h00);
    send_request(REQ_EXECUTE, 16'h0000, 8'h00);
    send_request(REQ_EXECUTE, 16'h0000, 8'h00);
    send_request(REQ_EXECUTE, 16'h0000, 8'h00);
    send_request(REQ_EXECUTE, 16'h0000, 8'h00);
    send_request(REQ_EXECUTE, 16'h0000, 8'h00);
    send_request(REQ_UNDO, 16'h0000, 8'h00);

    // random chunks steer occupancy to both full and empty corners
    for (int c = 0; c < CHUNKS; c++) begin
      calm = (c % 3 == 1);
      if (c == 1) long_hold_req = 1'b1;
      if (c == 4) wait_drained();
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < enq_pct[c]) req = REQ_ENQUEUE;
        else if (r < enq_pct[c] + exec_pct[c]) req = REQ_EXECUTE;
        else if (r < 97) req = REQ_UNDO;
        else req = REQ_RESERVED;
        send_request(req, pick_id(), pick_prio());
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/fwus_pkg.sv
hdl/fwus_ctrl.sv
hdl/fwus_dp.sv
hdl/fifo_with_undo_stack_core.sv
sim/fifo_with_undo_stack_core_tb.sv
